### rtl/dsfp_pkg.sv
// Package for the particle sensor frame parser with silence watchdog.
// Holds widths, frame byte codes, event codes and the queue entry type.
// No dependencies.
package dsfp_pkg;

  localparam int TIMER_BITS = 20;
  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int POS_W      = 4;
  localparam int NUM_STORED = 8;
  localparam int STORE_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SILENCE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY = 1'd1;

  localparam logic [CFG_W-1:0] SILENCE_RESET  = 20'd10000;
  localparam logic [CFG_W-1:0] RECOVERY_RESET = 20'd30000;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] CMD_BYTE   = 8'hC0;
  localparam logic [7:0] TAIL_BYTE  = 8'hAB;
  localparam logic [7:0] STREAK_MAX = 8'd255;

  localparam logic [POS_W-1:0] POS_HUNT  = 4'd0;
  localparam logic [POS_W-1:0] POS_FIRST = 4'd1;
  localparam logic [POS_W-1:0] POS_SUM_LO = 4'd2;
  localparam logic [POS_W-1:0] POS_SUM_HI = 4'd7;
  localparam logic [POS_W-1:0] POS_LAST  = 4'd9;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_VALID    = 2'd1;
  localparam logic [1:0] EV_BAD_HDR  = 2'd2;
  localparam logic [1:0] EV_BAD_SUM  = 2'd3;

  typedef struct packed {
    logic       is_tick;
    logic       is_start;
    logic       is_tail;
    logic [7:0] data;
  } cls_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

### rtl/dsfp_if.sv
// Channel interfaces for the particle sensor frame parser.
// Depends on nothing; used by the top level.
interface dsfp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface dsfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_event;
  logic [15:0] fine_dust_tenths;
  logic [15:0] coarse_dust_tenths;
  logic        readings_valid;
  logic        sensor_ok;
  logic [7:0]  failure_streak;
  logic        timed_out;
  logic        restart_request;

  modport source (output valid, output frame_event, output fine_dust_tenths,
                  output coarse_dust_tenths, output readings_valid, output sensor_ok,
                  output failure_streak, output timed_out, output restart_request,
                  input ready);
  modport sink   (input valid, input frame_event, input fine_dust_tenths,
                  input coarse_dust_tenths, input readings_valid, input sensor_ok,
                  input failure_streak, input timed_out, input restart_request,
                  output ready);
endinterface

### rtl/dsfp_front.sv
// Front stage: accepts input words, classifies them and registers the result.
// Depends on dsfp_pkg.
module dsfp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [7:0]        in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output dsfp_pkg::cls_t    push_item
);

  logic           stg_v_r, stg_v_nxt;
  dsfp_pkg::cls_t stg_r;
  dsfp_pkg::cls_t cls;
  logic           take;

  assign in_ready   = !stg_v_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = stg_v_r;
  assign push_item  = stg_r;

  always_comb begin
    cls.is_tick  = in_action;
    cls.is_start = (in_data == dsfp_pkg::START_BYTE);
    cls.is_tail  = (in_data == dsfp_pkg::TAIL_BYTE);
    cls.data     = in_data;
  end

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (take) begin
      stg_v_nxt = 1'b1;
    end else if (push_ready) begin
      stg_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg_r <= cls;
    end
  end

endmodule

### rtl/dsfp_queue.sv
// Two-entry queue of classified words between the front and back stages.
// Depends on dsfp_pkg.
module dsfp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  dsfp_pkg::cls_t    push_item,
  output dsfp_pkg::hs_t     pop_hs_o,
  input  logic              pop_ready,
  output dsfp_pkg::cls_t    pop_item
);

  dsfp_pkg::cls_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;

  assign push_ready     = (cnt_r != 2'd2);
  assign pop_hs_o.valid = (cnt_r != 2'd0);
  assign pop_hs_o.ready = pop_ready;
  assign push           = push_valid && push_ready;
  assign pop            = pop_hs_o.valid && pop_ready;
  assign pop_item       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/dsfp_back.sv
// Back stage: frame assembly, checksum, readings, silence watchdog and the
// result register. Depends on dsfp_pkg.
module dsfp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dsfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dsfp_pkg::CFG_W-1:0]    cfg_wdata,
  input  dsfp_pkg::hs_t                 pop_hs_i,
  output logic                          pop_ready,
  input  dsfp_pkg::cls_t                item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_event,
  output logic [15:0]                   out_fine,
  output logic [15:0]                   out_coarse,
  output logic                          out_rd_valid,
  output logic                          out_ok,
  output logic [7:0]                    out_streak,
  output logic                          out_tmo,
  output logic                          out_rst_req
);

  logic [dsfp_pkg::CFG_W-1:0]      sil_to_r, rec_to_r;
  logic [dsfp_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [7:0]                      fb_r [dsfp_pkg::NUM_STORED];
  logic [7:0]                      sum_r, sum_nxt;
  logic [dsfp_pkg::TIMER_BITS-1:0] sil_r, sil_nxt, sil_inc;
  logic                            ok_r, ok_nxt;
  logic                            val_r, val_nxt;
  logic [15:0]                     fine_r, fine_nxt;
  logic [15:0]                     coarse_r, coarse_nxt;
  logic [7:0]                      streak_r, streak_nxt;
  logic [7:0]                      streak_up;
  logic                            ov_r, ov_nxt;
  logic [1:0]                      ev_r, ev_nxt;
  logic                            tmo_r, tmo_nxt;
  logic                            rq_r, rq_nxt;
  logic                            fire, fb_we;
  logic [dsfp_pkg::POS_W-1:0]      pos_m1;
  logic [dsfp_pkg::STORE_IDX_W-1:0] fb_idx;
  logic [dsfp_pkg::CMP_W-1:0]      sil_cmp, sil_to_cmp, rec_to_cmp;

  assign pop_ready = !ov_r || out_ready;
  assign fire      = pop_hs_i.valid && pop_hs_i.ready;
  assign pos_m1    = pos_r - 4'd1;
  assign fb_idx    = pos_m1[dsfp_pkg::STORE_IDX_W-1:0];
  assign streak_up = (streak_r < dsfp_pkg::STREAK_MAX) ? streak_r + 8'd1 : streak_r;
  assign sil_inc   = (sil_r == dsfp_pkg::TIMER_MAX) ? sil_r
                                                    : sil_r + {{(dsfp_pkg::TIMER_BITS-1){1'b0}}, 1'b1};
  assign sil_cmp    = dsfp_pkg::CMP_W'(sil_inc);
  assign sil_to_cmp = dsfp_pkg::CMP_W'(sil_to_r);
  assign rec_to_cmp = dsfp_pkg::CMP_W'(rec_to_r);

  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    sil_nxt    = sil_r;
    ok_nxt     = ok_r;
    val_nxt    = val_r;
    fine_nxt   = fine_r;
    coarse_nxt = coarse_r;
    streak_nxt = streak_r;
    ev_nxt     = ev_r;
    tmo_nxt    = tmo_r;
    rq_nxt     = rq_r;
    fb_we      = 1'b0;
    ov_nxt     = ov_r && !out_ready;
    if (fire) begin
      ov_nxt  = 1'b1;
      ev_nxt  = dsfp_pkg::EV_NONE;
      tmo_nxt = 1'b0;
      rq_nxt  = 1'b0;
      if (item.is_tick) begin
        sil_nxt = sil_inc;
        if (sil_cmp > sil_to_cmp) begin
          tmo_nxt    = 1'b1;
          ok_nxt     = 1'b0;
          val_nxt    = 1'b0;
          fine_nxt   = 16'd0;
          coarse_nxt = 16'd0;
        end
        if (!ok_nxt && (sil_cmp > rec_to_cmp)) begin
          rq_nxt     = 1'b1;
          sil_nxt    = '0;
          streak_nxt = 8'd0;
          pos_nxt    = dsfp_pkg::POS_HUNT;
          sum_nxt    = 8'd0;
        end
      end else if (pos_r == dsfp_pkg::POS_HUNT || pos_r > dsfp_pkg::POS_LAST) begin
        pos_nxt = item.is_start ? dsfp_pkg::POS_FIRST : dsfp_pkg::POS_HUNT;
        sum_nxt = 8'd0;
      end else if (pos_r < dsfp_pkg::POS_LAST) begin
        fb_we   = 1'b1;
        pos_nxt = pos_r + 4'd1;
        if (pos_r >= dsfp_pkg::POS_SUM_LO && pos_r <= dsfp_pkg::POS_SUM_HI) begin
          sum_nxt = sum_r + item.data;
        end
      end else begin
        if (fb_r[0] != dsfp_pkg::CMD_BYTE || !item.is_tail) begin
          streak_nxt = streak_up;
          ev_nxt     = dsfp_pkg::EV_BAD_HDR;
        end else if (sum_r != fb_r[7]) begin
          streak_nxt = streak_up;
          ev_nxt     = dsfp_pkg::EV_BAD_SUM;
        end else begin
          fine_nxt   = {fb_r[2], fb_r[1]};
          coarse_nxt = {fb_r[4], fb_r[3]};
          val_nxt    = 1'b1;
          ok_nxt     = 1'b1;
          streak_nxt = 8'd0;
          sil_nxt    = '0;
          ev_nxt     = dsfp_pkg::EV_VALID;
        end
        pos_nxt = dsfp_pkg::POS_HUNT;
        sum_nxt = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sil_to_r <= dsfp_pkg::SILENCE_RESET;
      rec_to_r <= dsfp_pkg::RECOVERY_RESET;
      pos_r    <= dsfp_pkg::POS_HUNT;
      sum_r    <= 8'd0;
      sil_r    <= '0;
      ok_r     <= 1'b0;
      val_r    <= 1'b0;
      fine_r   <= 16'd0;
      coarse_r <= 16'd0;
      streak_r <= 8'd0;
      ov_r     <= 1'b0;
      ev_r     <= dsfp_pkg::EV_NONE;
      tmo_r    <= 1'b0;
      rq_r     <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == dsfp_pkg::REG_SILENCE) begin
        sil_to_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == dsfp_pkg::REG_RECOVERY) begin
        rec_to_r <= cfg_wdata;
      end
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      sil_r    <= sil_nxt;
      ok_r     <= ok_nxt;
      val_r    <= val_nxt;
      fine_r   <= fine_nxt;
      coarse_r <= coarse_nxt;
      streak_r <= streak_nxt;
      ov_r     <= ov_nxt;
      ev_r     <= ev_nxt;
      tmo_r    <= tmo_nxt;
      rq_r     <= rq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb_r[fb_idx] <= item.data;
    end
  end

  assign out_valid    = ov_r;
  assign out_event    = ev_r;
  assign out_fine     = fine_r;
  assign out_coarse   = coarse_r;
  assign out_rd_valid = val_r;
  assign out_ok       = ok_r;
  assign out_streak   = streak_r;
  assign out_tmo      = tmo_r;
  assign out_rst_req  = rq_r;

endmodule

### rtl/dust_sensor_frame_parser_watchdog_core.sv
// Particle sensor frame parser with silence watchdog, top level.
// Depends on dsfp_pkg, dsfp_if, dsfp_front, dsfp_queue and dsfp_back.
// Each input word (a UART byte or a millisecond tick) yields exactly one result word.
// The block takes one word per cycle while the result side is not stalled; a word passes
// the front register, the queue and the result register on its way to the result. Each
// byte or tick is applied to the frame and watchdog state in the back stage.
module dust_sensor_frame_parser_watchdog_core (
  input  logic                           clk,
  input  logic                           rst_n,
  dsfp_in_if.sink                        in_chan,
  dsfp_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [dsfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dsfp_pkg::CFG_W-1:0]     cfg_wdata
);

  logic           push_valid, push_ready, pop_ready;
  dsfp_pkg::cls_t push_item, pop_item;
  dsfp_pkg::hs_t  pop_hs;

  dsfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_action  (in_chan.action),
    .in_data    (in_chan.rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  dsfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_hs_o   (pop_hs),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  dsfp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .pop_hs_i     (pop_hs),
    .pop_ready    (pop_ready),
    .item         (pop_item),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_event    (out_chan.frame_event),
    .out_fine     (out_chan.fine_dust_tenths),
    .out_coarse   (out_chan.coarse_dust_tenths),
    .out_rd_valid (out_chan.readings_valid),
    .out_ok       (out_chan.sensor_ok),
    .out_streak   (out_chan.failure_streak),
    .out_tmo      (out_chan.timed_out),
    .out_rst_req  (out_chan.restart_request)
  );

endmodule

### tb/dust_sensor_frame_parser_watchdog_core_tb.sv
// Testbench for the particle sensor frame parser with silence watchdog.
// Drives bytes and ticks, predicts every status word and checks it on arrival.
// Depends on dsfp_pkg, dsfp_if and dust_sensor_frame_parser_watchdog_core.
module dust_sensor_frame_parser_watchdog_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int SHOW_MAX = 10;
  localparam int FEED_DEPTH = 256;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 190;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } sensor_word_t;

  typedef struct packed {
    logic [1:0]  frame_event;
    logic [15:0] fine;
    logic [15:0] coarse;
    logic        readings_valid;
    logic        sensor_ok;
    logic [7:0]  streak;
    logic        timed_out;
    logic        restart_request;
  } status_t;

  typedef enum logic [1:0] {FR_GOOD, FR_BAD_CMD, FR_BAD_TAIL, FR_BAD_SUM} frame_kind_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [dsfp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dsfp_pkg::CFG_W-1:0]     cfg_wdata;

  dsfp_in_if  in_chan();
  dsfp_out_if out_chan();

  dust_sensor_frame_parser_watchdog_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [dsfp_pkg::POS_W-1:0]      hunt_pos      = dsfp_pkg::POS_HUNT;
  logic [7:0]                      frame_buf [0:7];
  logic [7:0]                      frame_sum     = '0;
  logic [dsfp_pkg::TIMER_BITS-1:0] quiet_ms      = '0;
  logic                            ok_now        = 1'b0;
  logic                            rd_valid      = 1'b0;
  logic [15:0]                     pm_fine       = '0;
  logic [15:0]                     pm_coarse     = '0;
  logic [7:0]                      bad_run       = '0;
  logic [dsfp_pkg::CFG_W-1:0]      quiet_limit   = dsfp_pkg::SILENCE_RESET;
  logic [dsfp_pkg::CFG_W-1:0]      recover_limit = dsfp_pkg::RECOVERY_RESET;

  sensor_word_t word_feed[$];
  status_t      status_due[$];
  int unsigned  cycle_count = 0;
  int           mismatches  = 0;
  bit           idle_on     = 1'b0;
  bit           in_took     = 1'b0;
  int           gap_left    = 0;
  int           stall_left  = 0;

  function automatic status_t next_status(input sensor_word_t w);
    status_t    s;
    logic [2:0] slot;
    s = '0;
    if (w.action == ACT_BYTE) begin
      if (hunt_pos == dsfp_pkg::POS_HUNT || hunt_pos > dsfp_pkg::POS_LAST) begin
        hunt_pos  = (w.rx_byte == dsfp_pkg::START_BYTE) ? dsfp_pkg::POS_FIRST
                                                        : dsfp_pkg::POS_HUNT;
        frame_sum = '0;
      end else if (hunt_pos < dsfp_pkg::POS_LAST) begin
        slot = 3'(hunt_pos - dsfp_pkg::POS_FIRST);
        frame_buf[slot] = w.rx_byte;
        if (hunt_pos >= dsfp_pkg::POS_SUM_LO && hunt_pos <= dsfp_pkg::POS_SUM_HI) begin
          frame_sum = frame_sum + w.rx_byte;
        end
        hunt_pos = hunt_pos + 4'd1;
      end else begin
        if (frame_buf[0] != dsfp_pkg::CMD_BYTE || w.rx_byte != dsfp_pkg::TAIL_BYTE) begin
          if (bad_run != dsfp_pkg::STREAK_MAX) bad_run = bad_run + 8'd1;
          s.frame_event = dsfp_pkg::EV_BAD_HDR;
        end else if (frame_sum != frame_buf[7]) begin
          if (bad_run != dsfp_pkg::STREAK_MAX) bad_run = bad_run + 8'd1;
          s.frame_event = dsfp_pkg::EV_BAD_SUM;
        end else begin
          pm_fine       = {frame_buf[2], frame_buf[1]};
          pm_coarse     = {frame_buf[4], frame_buf[3]};
          rd_valid      = 1'b1;
          ok_now        = 1'b1;
          bad_run       = '0;
          quiet_ms      = '0;
          s.frame_event = dsfp_pkg::EV_VALID;
        end
        hunt_pos  = dsfp_pkg::POS_HUNT;
        frame_sum = '0;
      end
    end else begin
      if (quiet_ms != dsfp_pkg::TIMER_MAX) quiet_ms = quiet_ms + dsfp_pkg::TIMER_BITS'(1);
      if (quiet_ms > quiet_limit) begin
        s.timed_out = 1'b1;
        ok_now      = 1'b0;
        rd_valid    = 1'b0;
        pm_fine     = '0;
        pm_coarse   = '0;
      end
      if (!ok_now && quiet_ms > recover_limit) begin
        s.restart_request = 1'b1;
        quiet_ms  = '0;
        bad_run   = '0;
        hunt_pos  = dsfp_pkg::POS_HUNT;
        frame_sum = '0;
      end
    end
    s.fine           = pm_fine;
    s.coarse         = pm_coarse;
    s.readings_valid = rd_valid;
    s.sensor_ok      = ok_now;
    s.streak         = bad_run;
    return s;
  endfunction

  task automatic feed(input logic act, input logic [7:0] b);
    sensor_word_t w;
    while (word_feed.size() >= FEED_DEPTH) @(posedge clk);
    w.action  = act;
    w.rx_byte = b;
    word_feed.push_back(w);
  endtask

  task automatic feed_tick();
    feed(ACT_TICK, 8'($urandom));
  endtask

  task automatic push_frame(input frame_kind_t kind, input logic [15:0] fine,
                            input logic [15:0] coarse, input logic [7:0] r1,
                            input logic [7:0] r2);
    logic [7:0] cmd, tail, chk, flip;
    cmd  = dsfp_pkg::CMD_BYTE;
    tail = dsfp_pkg::TAIL_BYTE;
    chk  = fine[7:0] + fine[15:8] + coarse[7:0] + coarse[15:8] + r1 + r2;
    flip = 8'($urandom_range(1, 255));
    case (kind)
      FR_BAD_CMD:  cmd  = cmd ^ flip;
      FR_BAD_TAIL: tail = tail ^ flip;
      FR_BAD_SUM:  chk  = chk ^ flip;
      default: ;
    endcase
    feed(ACT_BYTE, dsfp_pkg::START_BYTE);
    feed(ACT_BYTE, cmd);
    feed(ACT_BYTE, fine[7:0]);
    feed(ACT_BYTE, fine[15:8]);
    feed(ACT_BYTE, coarse[7:0]);
    feed(ACT_BYTE, coarse[15:8]);
    feed(ACT_BYTE, r1);
    feed(ACT_BYTE, r2);
    feed(ACT_BYTE, chk);
    feed(ACT_BYTE, tail);
  endtask

  task automatic write_reg(input logic [dsfp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dsfp_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == dsfp_pkg::REG_SILENCE) quiet_limit = val;
    else recover_limit = val;
    @(negedge clk);
    cfg_we = 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    while (word_feed.size() != 0 || status_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic note_fault(input string why, input status_t e, input status_t g);
    mismatches++;
    if (mismatches <= SHOW_MAX) begin
      $display("%0t %s: exp ev=%0d pm25=%0d pm10=%0d vld=%0b ok=%0b streak=%0d tmo=%0b rst=%0b",
               $realtime, why, e.frame_event, e.fine, e.coarse, e.readings_valid,
               e.sensor_ok, e.streak, e.timed_out, e.restart_request);
      $display("%0t %s: got ev=%0d pm25=%0d pm10=%0d vld=%0b ok=%0b streak=%0d tmo=%0b rst=%0b",
               $realtime, why, g.frame_event, g.fine, g.coarse, g.readings_valid,
               g.sensor_ok, g.streak, g.timed_out, g.restart_request);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin : take_word
    sensor_word_t w;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      w = word_feed.pop_front();
      status_due.push_back(next_status(w));
      in_took = 1'b1;
    end else begin
      in_took = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid   <= 1'b0;
      in_chan.action  <= ACT_BYTE;
      in_chan.rx_byte <= '0;
    end else if (!(in_chan.valid && !in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_chan.valid <= 1'b0;
      end else if (word_feed.size() == 0) begin
        in_chan.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 8);
        in_chan.valid <= 1'b0;
      end else begin
        in_chan.valid   <= 1'b1;
        in_chan.action  <= word_feed[0].action;
        in_chan.rx_byte <= word_feed[0].rx_byte;
      end
    end
  end

  // monitor
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_word
    status_t got, want;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end else if (rst_n && out_chan.valid && out_chan.ready) begin
      got = {out_chan.frame_event, out_chan.fine_dust_tenths, out_chan.coarse_dust_tenths,
             out_chan.readings_valid, out_chan.sensor_ok, out_chan.failure_streak,
             out_chan.timed_out, out_chan.restart_request};
      if (status_due.size() == 0) begin
        note_fault("unexpected word", '0, got);
      end else begin
        want = status_due.pop_front();
        if (got !== want) note_fault("mismatch", want, got);
      end
    end
  end

  initial begin : stimulus
    int made;
    int pick;
    int n;
    frame_kind_t kind;
    logic [15:0] f, c;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    idle_on = 1'b1;
    feed_tick();
    feed(ACT_BYTE, 8'h00);
    feed(ACT_BYTE, 8'hFF);
    push_frame(FR_GOOD, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    push_frame(FR_BAD_SUM, 16'h0000, 16'h0000, 8'h00, 8'h00);
    push_frame(FR_BAD_CMD, 16'h1234, 16'h5678, 8'h00, 8'h00);
    feed_tick();
    settle();
    write_reg(dsfp_pkg::REG_SILENCE, '0);
    feed_tick();
    feed(ACT_BYTE, dsfp_pkg::START_BYTE);
    feed(ACT_BYTE, dsfp_pkg::CMD_BYTE);
    feed(ACT_BYTE, 8'h33);
    settle();
    write_reg(dsfp_pkg::REG_RECOVERY, '0);
    feed_tick();
    push_frame(FR_BAD_TAIL, 16'h00FF, 16'hFF00, 8'h5A, 8'hA5);
    push_frame(FR_GOOD, 16'h0000, 16'h0000, 8'h5A, 8'hA5);
    settle();

    write_reg(dsfp_pkg::REG_SILENCE, dsfp_pkg::TIMER_MAX - dsfp_pkg::TIMER_BITS'(1));
    write_reg(dsfp_pkg::REG_RECOVERY, dsfp_pkg::TIMER_MAX - dsfp_pkg::TIMER_BITS'(1));
    feed_tick();
    feed_tick();
    settle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          write_reg(dsfp_pkg::REG_SILENCE, 20'd1);
          write_reg(dsfp_pkg::REG_RECOVERY, 20'd1);
        end
        1: begin
          write_reg(dsfp_pkg::REG_SILENCE, dsfp_pkg::CFG_W'($urandom_range(5, 30)));
          write_reg(dsfp_pkg::REG_RECOVERY, dsfp_pkg::CFG_W'($urandom_range(10, 40)));
        end
        2: begin
          write_reg(dsfp_pkg::REG_SILENCE, dsfp_pkg::TIMER_MAX);
          write_reg(dsfp_pkg::REG_RECOVERY, dsfp_pkg::TIMER_MAX);
        end
        3: begin
          write_reg(dsfp_pkg::REG_SILENCE, dsfp_pkg::CFG_W'($urandom_range(1, 40)));
          write_reg(dsfp_pkg::REG_RECOVERY, dsfp_pkg::CFG_W'($urandom_range(1, 20)));
        end
        4: begin
          write_reg(dsfp_pkg::REG_SILENCE, dsfp_pkg::CFG_W'($urandom_range(1, 1048575)));
          write_reg(dsfp_pkg::REG_RECOVERY, dsfp_pkg::CFG_W'($urandom_range(1, 60)));
        end
        default: begin
          write_reg(dsfp_pkg::REG_SILENCE, dsfp_pkg::CFG_W'($urandom_range(5, 30)));
          write_reg(dsfp_pkg::REG_RECOVERY, dsfp_pkg::CFG_W'($urandom_range(30, 60)));
        end
      endcase
      idle_on = (phase != NUM_PHASES - 1);
      made = 0;
      while (made < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          f = 16'($urandom);
          c = 16'($urandom);
          if ($urandom_range(0, 7) == 0) f = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          if ($urandom_range(0, 7) == 0) c = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          n = $urandom_range(0, 9);
          if (n == 9) begin
            feed(ACT_BYTE, dsfp_pkg::START_BYTE);
            repeat ($urandom_range(1, 8)) feed(ACT_BYTE, 8'($urandom));
            made += 5;
          end else begin
            kind = (n < 6) ? FR_GOOD : (n == 6) ? FR_BAD_CMD : (n == 7) ? FR_BAD_TAIL
                                                                          : FR_BAD_SUM;
            push_frame(kind, f, c, 8'($urandom), 8'($urandom));
            made += 10;
          end
        end else if (pick < 80) begin
          n = $urandom_range(1, 40);
          repeat (n) feed_tick();
          made += n;
        end else begin
          repeat ($urandom_range(1, 3)) begin
            feed(ACT_BYTE, ($urandom_range(0, 3) == 0) ? dsfp_pkg::START_BYTE
                                                        : 8'($urandom));
          end
        end
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
